@@ hdl/bb3_pkg.sv @@
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // register and field widths
  localparam int WREG_W = 11;
  localparam int HREG_W = 13;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;

  // counters: the input row runs one past the frame while draining
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int UW_W   = $clog2(MAX_WIDTH + 1);
  localparam int UH_W   = $clog2(MAX_HEIGHT + 1);

  // neighborhood arithmetic
  localparam int RSUM_W      = CH_W + 2;
  localparam int SUM_W       = CH_W + 4;
  localparam int NUM_W       = SUM_W + 1;
  localparam int CNT_W       = 4;
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = NUM_W + RECIP_W;

  // register index (paddr bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // color channel select
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_ROW,
    ST_TOTAL,
    ST_DIV_R,
    ST_DIV_G,
    ST_DIV_B,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [UW_W-1:0] used_width;
    logic [UH_W-1:0] used_height;
    logic            clear;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       shift;
    logic       row_sum;
    logic       total;
    logic       div_en;
    logic [1:0] div_ch;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic emit;
    logic out_busy;
  } dp_status_t;

  function automatic logic [UW_W-1:0] clamp_width(logic [WREG_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x == 32'd0) begin
      x = 32'd1;
    end else if (x > 32'(MAX_WIDTH)) begin
      x = 32'(MAX_WIDTH);
    end
    return UW_W'(x);
  endfunction

  function automatic logic [UH_W-1:0] clamp_height(logic [HREG_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x == 32'd0) begin
      x = 32'd1;
    end else if (x > 32'(MAX_HEIGHT)) begin
      x = 32'(MAX_HEIGHT);
    end
    return UH_W'(x);
  endfunction

  // ceil(2^18 / (2*count)); exact floor division for numerators below 2^13
  function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] m;
    unique case (count)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd5:    m = 18'd26215;
      4'd6:    m = 18'd21846;
      4'd7:    m = 18'd18725;
      4'd8:    m = 18'd16384;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ hdl/bb3_in_if.sv @@
interface bb3_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [bb3_pkg::CH_W-1:0]   red_in;
  logic [bb3_pkg::CH_W-1:0]   green_in;
  logic [bb3_pkg::CH_W-1:0]   blue_in;

  modport source (output valid, command, red_in, green_in, blue_in, input ready);
  modport sink (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

@@ hdl/bb3_out_if.sv @@
interface bb3_out_if;
  logic                       valid;
  logic                       ready;
  logic [bb3_pkg::CH_W-1:0]   red_out;
  logic [bb3_pkg::CH_W-1:0]   green_out;
  logic [bb3_pkg::CH_W-1:0]   blue_out;
  logic                       frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

@@ hdl/bb3_ram.sv @@
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/bb3_cfg.sv @@
module bb3_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bb3_pkg::ADDR_W-1:0]  paddr,
  input  logic [bb3_pkg::DATA_W-1:0]  pwdata,
  output logic [bb3_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bb3_pkg::cfg_t               cfg
);

  logic [bb3_pkg::WREG_W-1:0] image_width;
  logic [bb3_pkg::HREG_W-1:0] image_height;
  logic                       wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bb3_pkg::WREG_W'(640);
      image_height <= bb3_pkg::HREG_W'(480);
    end else if (wr) begin
      if (paddr[2] == bb3_pkg::REG_WIDTH) begin
        image_width <= pwdata[bb3_pkg::WREG_W-1:0];
      end else begin
        image_height <= pwdata[bb3_pkg::HREG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == bb3_pkg::REG_WIDTH) begin
      prdata = bb3_pkg::DATA_W'(image_width);
    end else begin
      prdata = bb3_pkg::DATA_W'(image_height);
    end
  end

  assign cfg.used_width  = bb3_pkg::clamp_width(image_width);
  assign cfg.used_height = bb3_pkg::clamp_height(image_height);
  assign cfg.clear       = wr;

endmodule

@@ hdl/bb3_ctrl.sv @@
module bb3_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bb3_pkg::dp_status_t status,
  output bb3_pkg::dp_cmd_t    cmd
);

  bb3_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bb3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bb3_pkg::ST_IDLE: begin
        if (in_valid && !status.skip) begin
          state_next = bb3_pkg::ST_SHIFT;
        end
      end
      bb3_pkg::ST_SHIFT: begin
        state_next = status.emit ? bb3_pkg::ST_ROW : bb3_pkg::ST_IDLE;
      end
      bb3_pkg::ST_ROW:   state_next = bb3_pkg::ST_TOTAL;
      bb3_pkg::ST_TOTAL: state_next = bb3_pkg::ST_DIV_R;
      bb3_pkg::ST_DIV_R: state_next = bb3_pkg::ST_DIV_G;
      bb3_pkg::ST_DIV_G: state_next = bb3_pkg::ST_DIV_B;
      bb3_pkg::ST_DIV_B: state_next = bb3_pkg::ST_OUT;
      bb3_pkg::ST_OUT: begin
        if (!status.out_busy) begin
          state_next = bb3_pkg::ST_IDLE;
        end
      end
      default: state_next = bb3_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      bb3_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid && !status.skip;
      end
      bb3_pkg::ST_SHIFT: cmd.shift   = 1'b1;
      bb3_pkg::ST_ROW:   cmd.row_sum = 1'b1;
      bb3_pkg::ST_TOTAL: cmd.total   = 1'b1;
      bb3_pkg::ST_DIV_R: begin
        cmd.div_en = 1'b1;
        cmd.div_ch = bb3_pkg::CH_RED;
      end
      bb3_pkg::ST_DIV_G: begin
        cmd.div_en = 1'b1;
        cmd.div_ch = bb3_pkg::CH_GREEN;
      end
      bb3_pkg::ST_DIV_B: begin
        cmd.div_en = 1'b1;
        cmd.div_ch = bb3_pkg::CH_BLUE;
      end
      bb3_pkg::ST_OUT: cmd.load_out = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hdl/bb3_dp.sv @@
module bb3_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  bb3_pkg::cfg_t             cfg,
  input  bb3_pkg::dp_cmd_t          cmd,
  output bb3_pkg::dp_status_t       status,
  input  logic                      command,
  input  logic [bb3_pkg::CH_W-1:0]  red_in,
  input  logic [bb3_pkg::CH_W-1:0]  green_in,
  input  logic [bb3_pkg::CH_W-1:0]  blue_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bb3_pkg::CH_W-1:0]  red_out,
  output logic [bb3_pkg::CH_W-1:0]  green_out,
  output logic [bb3_pkg::CH_W-1:0]  blue_out,
  output logic                      frame_end
);

  localparam int CH_W  = bb3_pkg::CH_W;
  localparam int PIX_W = bb3_pkg::PIX_W;

  logic [bb3_pkg::COL_W-1:0]   in_col;
  logic [bb3_pkg::IROW_W-1:0]  in_row;
  logic [bb3_pkg::COL_W-1:0]   out_col;
  logic [bb3_pkg::OROW_W-1:0]  out_row;
  logic [PIX_W-1:0]            pix;
  logic                        emit;
  logic [PIX_W-1:0]            window [3][3];
  logic [bb3_pkg::RSUM_W-1:0]  rsum [3][3];
  logic [bb3_pkg::CNT_W-1:0]   count;
  logic [bb3_pkg::NUM_W-1:0]   num [3];
  logic [CH_W-1:0]             quot [3];

  logic [PIX_W-1:0]            up_rd;
  logic [PIX_W-1:0]            lo_rd;
  logic                        drain;
  logic                        col_wrap;
  logic                        fe;
  logic [2:0]                  row_ok;
  logic [2:0]                  col_ok;
  logic [1:0]                  nrows;
  logic [1:0]                  ncols;
  logic [bb3_pkg::NUM_W-1:0]   num_sel;
  logic [bb3_pkg::PROD_W-1:0]  prod;

  function automatic logic [CH_W-1:0] chan(logic [PIX_W-1:0] p, int c);
    return p[PIX_W-1-CH_W*c -: CH_W];
  endfunction

  assign drain    = 32'(in_row) >= 32'(cfg.used_height);
  assign col_wrap = 32'(in_col) + 32'd1 >= 32'(cfg.used_width);
  assign fe       = (32'(out_row) + 32'd1 >= 32'(cfg.used_height)) &&
                    (32'(out_col) + 32'd1 >= 32'(cfg.used_width));

  assign status.skip     = (command == bb3_pkg::CMD_DRAIN) && !drain;
  assign status.emit     = emit;
  assign status.out_busy = out_valid && !out_ready;

  // upper store holds the row above the lower store
  bb3_ram #(.WIDTH(PIX_W), .DEPTH(bb3_pkg::MAX_WIDTH)) u_upper (
    .clk     (clk),
    .wr_en   (cmd.shift),
    .wr_addr (in_col),
    .wr_data (lo_rd),
    .rd_en   (cmd.accept),
    .rd_addr (in_col),
    .rd_data (up_rd)
  );

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(bb3_pkg::MAX_WIDTH)) u_lower (
    .clk     (clk),
    .wr_en   (cmd.shift),
    .wr_addr (in_col),
    .wr_data (pix),
    .rd_en   (cmd.accept),
    .rd_addr (in_col),
    .rd_data (lo_rd)
  );

  // position counters
  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (cmd.load_out && fe) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      if (cmd.shift) begin
        if (col_wrap) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (cmd.load_out) begin
        if (32'(out_col) + 32'd1 >= 32'(cfg.used_width)) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  // latch the word; a drain tick feeds black
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix  <= drain ? '0 : {red_in, green_in, blue_in};
      emit <= (in_row >= bb3_pkg::IROW_W'(2)) ||
              ((in_row == bb3_pkg::IROW_W'(1)) && (in_col != '0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          window[r][c] <= '0;
        end
      end
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        window[r][0] <= window[r][1];
        window[r][1] <= window[r][2];
      end
      window[0][2] <= up_rd;
      window[1][2] <= lo_rd;
      window[2][2] <= pix;
    end
  end

  // neighbors outside the frame drop out of sum and count
  assign row_ok[0] = out_row != '0;
  assign row_ok[1] = 1'b1;
  assign row_ok[2] = 32'(out_row) + 32'd1 < 32'(cfg.used_height);
  assign col_ok[0] = out_col != '0;
  assign col_ok[1] = 1'b1;
  assign col_ok[2] = 32'(out_col) + 32'd1 < 32'(cfg.used_width);
  assign nrows     = 2'd1 + 2'(row_ok[0]) + 2'(row_ok[2]);
  assign ncols     = 2'd1 + 2'(col_ok[0]) + 2'(col_ok[2]);

  always_ff @(posedge clk) begin
    if (cmd.row_sum) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int r = 0; r < 3; r++) begin
          rsum[ch][r] <=
            (col_ok[0] && row_ok[r] ? bb3_pkg::RSUM_W'(chan(window[r][0], ch)) : '0) +
            (col_ok[1] && row_ok[r] ? bb3_pkg::RSUM_W'(chan(window[r][1], ch)) : '0) +
            (col_ok[2] && row_ok[r] ? bb3_pkg::RSUM_W'(chan(window[r][2], ch)) : '0);
        end
      end
      count <= {2'b00, nrows} * {2'b00, ncols};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.total) begin
      for (int ch = 0; ch < 3; ch++) begin
        num[ch] <= {bb3_pkg::SUM_W'(rsum[ch][0]) + bb3_pkg::SUM_W'(rsum[ch][1]) +
                    bb3_pkg::SUM_W'(rsum[ch][2]), 1'b0} + bb3_pkg::NUM_W'(count);
      end
    end
  end

  // one shared reciprocal multiplier, a channel per cycle
  always_comb begin
    unique case (cmd.div_ch)
      bb3_pkg::CH_RED:   num_sel = num[0];
      bb3_pkg::CH_GREEN: num_sel = num[1];
      bb3_pkg::CH_BLUE:  num_sel = num[2];
      default:           num_sel = '0;
    endcase
  end

  assign prod = bb3_pkg::PROD_W'(num_sel) * bb3_pkg::PROD_W'(bb3_pkg::recip(count));

  always_ff @(posedge clk) begin
    if (cmd.div_en) begin
      unique case (cmd.div_ch)
        bb3_pkg::CH_RED:   quot[0] <= prod[bb3_pkg::RECIP_SHIFT +: CH_W];
        bb3_pkg::CH_GREEN: quot[1] <= prod[bb3_pkg::RECIP_SHIFT +: CH_W];
        bb3_pkg::CH_BLUE:  quot[2] <= prod[bb3_pkg::RECIP_SHIFT +: CH_W];
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      red_out   <= quot[0];
      green_out <= quot[1];
      blue_out  <= quot[2];
      frame_end <= fe;
    end
  end

endmodule

@@ hdl/box_blur_3x3_rgb.sv @@
// 3x3 box blur over an RGB pixel stream in raster order. Each color gets the
// mean of the in-frame neighbors of a pixel (itself included), rounded half
// up, with the divisor taken from how many neighbors fall inside the frame.
// Results trail the input by image_width+1 words; after the last pixel of a
// frame send image_width+1 drain words (command = 1) to flush the tail, and
// the last result carries frame_end. Drain words sent mid-frame are dropped;
// pixels sent while the tail is pending count as drain words. Writing
// image_width (offset 0) or image_height (offset 4) restarts the frame; write
// them only while the block is idle. Values of 0 act as 1, values above the
// maximum frame size act as that maximum.
// A word that produces no result is accepted, then passes the registered
// line-store read and window shift; a word that produces a result then has
// the sequencer form row sums, totals, and run the three colors one per cycle
// through a shared reciprocal multiplier before loading the output register.
// A drain word ignored mid-frame ends at acceptance. No new word is taken
// until the last is through. A result held by a stalled sink stretches the
// last step until the output register frees. The line stores need no clearing
// after reset: rows never written in a frame only feed neighbors outside it.
module box_blur_3x3_rgb (
  input  logic                        clk,
  input  logic                        rst,
  bb3_in_if.sink                      pix_in,
  bb3_out_if.source                   pix_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bb3_pkg::ADDR_W-1:0]  paddr,
  input  logic [bb3_pkg::DATA_W-1:0]  pwdata,
  output logic [bb3_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  bb3_pkg::cfg_t       cfg;
  bb3_pkg::dp_cmd_t    cmd;
  bb3_pkg::dp_status_t status;
  logic                in_ready;
  logic                out_valid;
  logic [bb3_pkg::CH_W-1:0] red_q;
  logic [bb3_pkg::CH_W-1:0] green_q;
  logic [bb3_pkg::CH_W-1:0] blue_q;
  logic                frame_end_q;

  // frame geometry registers
  bb3_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: one word at a time through shift, sum, divide, output
  bb3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // line stores, window, counters, arithmetic and output register
  bb3_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .command   (pix_in.command),
    .red_in    (pix_in.red_in),
    .green_in  (pix_in.green_in),
    .blue_in   (pix_in.blue_in),
    .out_valid (out_valid),
    .out_ready (pix_out.ready),
    .red_out   (red_q),
    .green_out (green_q),
    .blue_out  (blue_q),
    .frame_end (frame_end_q)
  );

  assign pix_in.ready      = in_ready;
  assign pix_out.valid     = out_valid;
  assign pix_out.red_out   = red_q;
  assign pix_out.green_out = green_q;
  assign pix_out.blue_out  = blue_q;
  assign pix_out.frame_end = frame_end_q;

endmodule
